>>> hdl/ara_pkg.sv
// Shared types and constants of the address region allocator.
`default_nettype none
package ara_pkg;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_CHECK = 2'd2;

    localparam logic [1:0] ST_SUCCESS  = 2'd0;
    localparam logic [1:0] ST_NO_SPACE = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    localparam logic [7:0] REG_WINDOW_BASE   = 8'd0;
    localparam logic [7:0] REG_WINDOW_LENGTH = 8'd1;

    localparam logic [49:0] SZ_64K     = 50'h10000;
    localparam logic [49:0] SZ_2M      = 50'h200000;
    localparam logic [49:0] SZ_4M      = 50'h400000;
    localparam logic [49:0] SZ_32M     = 50'h2000000;
    localparam logic [49:0] SZ_1G      = 50'h40000000;
    localparam logic [49:0] LOWER_SIZE = SZ_1G - SZ_2M;
    localparam logic [48:0] ADDR_TOP   = 49'h1000000000000;

    typedef struct packed {
        logic eval1;
        logic eval2;
        logic ins;
        logic del;
    } ara_ctrl_t;

    typedef struct packed {
        logic fit;
        logic ge;
        logic eq;
        logic len_ok;
        logic in_prev;
    } ara_flags_t;

endpackage
`default_nettype wire

>>> hdl/address_region_allocator.sv
// Top level of the address region allocator: request control, result pick and slot chain.
`default_nettype none
// Keeps a sorted table of up to MAX_REGIONS allocated regions inside a configured
// window, held one region per slot in a chain of slots. The request register loads
// when a transaction is accepted. Per-slot gap and range evaluation follows in
// states EV1 and EV2, then priority pick and table update in state PICK load the
// output register. One transaction is processed at a time, and the next one is
// accepted in the cycle after the result is loaded. A result held by a stalled
// output keeps the pick state waiting, and the input stays stalled meanwhile.
// Writing either window register empties the table.
module address_region_allocator #(
    parameter int MAX_REGIONS = 64,
    parameter int PAGE_BYTES = 4096
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  opcode,
    input  wire logic [47:0] req_address,
    input  wire logic [47:0] req_length,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [47:0]      granted_address,
    output logic [1:0]       status,
    output logic             is_allocated,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [47:0] cfg_data
);
    import ara_pkg::*;

    localparam int N  = MAX_REGIONS + 1;
    localparam int CW = $clog2(MAX_REGIONS + 1);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EV1  = 3'd1;
    localparam logic [2:0] S_EV2  = 3'd2;
    localparam logic [2:0] S_PICK = 3'd3;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [47:0]   base_reg, wlen_reg;
    logic [1:0]    op_reg;
    logic [47:0]   addr_reg, len_reg;
    logic [48:0]   aend_reg;
    logic [49:0]   am_reg, am_w;
    logic          out_valid_reg;
    logic [47:0]   gaddr_reg;
    logic [1:0]    status_reg;
    logic          alloc_reg;
    logic [48:0]   lower_sum, lower_end, mark_sum, mark;
    logic [49:0]   lower_len;
    ara_ctrl_t     ctrl;
    logic [CW-1:0] pos;
    logic          emit;
    logic [47:0]   r_gaddr;
    logic [1:0]    r_status;
    logic          r_alloc;

    logic [47:0] s_begin [N];
    logic [47:0] s_len   [N];
    logic [49:0] s_end   [N];
    logic [47:0] s_start [N];
    ara_flags_t  s_flags [N];

    logic          fit_any, ge_any, eq_any;
    logic [CW-1:0] fit_sel, ge_sel, eq_sel;

    assign lower_sum = {1'b0, base_reg} + LOWER_SIZE[48:0];
    assign lower_end = (lower_sum > ADDR_TOP) ? ADDR_TOP : lower_sum;
    assign lower_len = {1'b0, lower_end} - {2'b0, base_reg};
    assign mark_sum  = {1'b0, base_reg} + {1'b0, wlen_reg};
    assign mark      = (mark_sum > ADDR_TOP) ? ADDR_TOP : mark_sum;

    always_comb
    begin
        priority if ({2'b0, req_length} < SZ_2M)
            am_w = SZ_64K - 50'd1;
        else if ({2'b0, req_length} < SZ_4M)
            am_w = SZ_2M - 50'd1;
        else if ({2'b0, req_length} < SZ_32M)
            am_w = SZ_4M - 50'd1;
        else if ({2'b0, req_length} < SZ_1G)
            am_w = SZ_32M - 50'd1;
        else
            am_w = SZ_1G - 50'd1;
    end

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_slot
            ara_slot #(
                .IDX(g),
                .MAX_REGIONS(MAX_REGIONS),
                .PAGE_BYTES(PAGE_BYTES)
            ) u_slot (
                .clk(clk),
                .ctrl(ctrl),
                .count(count_reg),
                .pos(pos),
                .mark(mark),
                .prev_end((g == 0) ? {1'b0, lower_end} : s_end[(g == 0) ? 0 : g - 1]),
                .left_begin(s_begin[(g == 0) ? 0 : g - 1]),
                .left_len(s_len[(g == 0) ? 0 : g - 1]),
                .right_begin(s_begin[(g == N - 1) ? g : g + 1]),
                .right_len(s_len[(g == N - 1) ? g : g + 1]),
                .new_begin(r_gaddr),
                .new_len(len_reg),
                .req_addr(addr_reg),
                .req_len(len_reg),
                .addr_end(aend_reg),
                .align_mask(am_reg),
                .begin_q(s_begin[g]),
                .len_q(s_len[g]),
                .node_end(s_end[g]),
                .start_q(s_start[g]),
                .flags(s_flags[g])
            );
        end
    endgenerate

    always_comb
    begin
        fit_any = 1'b0;
        fit_sel = '0;
        for (int i = 0; i < N; i++)
        begin
            if (s_flags[i].fit)
            begin
                fit_any = 1'b1;
                fit_sel = CW'(i);
            end
        end
        ge_any = 1'b0;
        ge_sel = '0;
        eq_any = 1'b0;
        eq_sel = '0;
        for (int i = N - 1; i >= 0; i--)
        begin
            if (s_flags[i].ge)
            begin
                ge_any = 1'b1;
                ge_sel = CW'(i);
            end
            if (s_flags[i].eq && (CW'(i) < count_reg))
            begin
                eq_any = 1'b1;
                eq_sel = CW'(i);
            end
        end
    end

    always_comb
    begin
        r_gaddr  = 48'd0;
        r_status = ST_SUCCESS;
        r_alloc  = 1'b0;
        pos      = '0;
        ctrl     = '0;
        emit     = (state_reg == S_PICK) && !(out_valid_reg && out_stall);
        ctrl.eval1 = (state_reg == S_EV1);
        ctrl.eval2 = (state_reg == S_EV2);
        unique case (op_reg)
            OP_ALLOC:
            begin
                if (count_reg >= CW'(MAX_REGIONS))
                    r_status = ST_FULL;
                else if (fit_any)
                begin
                    r_gaddr  = s_start[fit_sel];
                    pos      = fit_sel;
                    ctrl.ins = emit;
                end
                else
                    r_status = ST_NO_SPACE;
            end
            OP_FREE:
            begin
                if (eq_any)
                begin
                    pos      = eq_sel;
                    ctrl.del = emit;
                end
                else
                    r_status = ST_NOTFOUND;
            end
            OP_CHECK:
            begin
                if (base_reg >= addr_reg)
                    r_alloc = (base_reg == addr_reg) && ({2'b0, len_reg} <= lower_len);
                else if (ge_any)
                    r_alloc = s_flags[ge_sel].eq ? s_flags[ge_sel].len_ok
                                                 : s_flags[ge_sel].in_prev;
                else
                    r_alloc = 1'b0;
            end
            default:
                r_status = ST_NOTFOUND;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        unique case (state_reg)
            S_IDLE:  if (in_valid) state_next = S_EV1;
            S_EV1:   state_next = S_EV2;
            S_EV2:   state_next = S_PICK;
            S_PICK:
            begin
                if (emit)
                begin
                    state_next = S_IDLE;
                    if (ctrl.ins)
                        count_next = count_reg + CW'(1);
                    else if (ctrl.del)
                        count_next = count_reg - CW'(1);
                end
            end
            default: state_next = S_IDLE;
        endcase
        if (cfg_valid && (cfg_index == REG_WINDOW_BASE || cfg_index == REG_WINDOW_LENGTH))
            count_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            base_reg      <= 48'd0;
            wlen_reg      <= 48'd0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            if (cfg_valid && cfg_index == REG_WINDOW_BASE)
                base_reg <= cfg_data;
            if (cfg_valid && cfg_index == REG_WINDOW_LENGTH)
                wlen_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            op_reg   <= opcode;
            addr_reg <= req_address;
            len_reg  <= req_length;
            aend_reg <= {1'b0, req_address} + {1'b0, req_length};
            am_reg   <= am_w;
        end
        if (emit)
        begin
            gaddr_reg  <= (r_status == ST_SUCCESS) ? r_gaddr : 48'd0;
            status_reg <= r_status;
            alloc_reg  <= r_alloc;
        end
    end

    assign in_stall        = (state_reg != S_IDLE);
    assign cfg_ready       = 1'b1;
    assign out_valid       = out_valid_reg;
    assign granted_address = gaddr_reg;
    assign status          = status_reg;
    assign is_allocated    = alloc_reg;

endmodule
`default_nettype wire

>>> hdl/ara_slot.sv
// One slot of the region chain: holds one stored region and evaluates its gap.
`default_nettype none
module ara_slot #(
    parameter int IDX = 0,
    parameter int MAX_REGIONS = 64,
    parameter int PAGE_BYTES = 4096,
    localparam int CW = $clog2(MAX_REGIONS + 1)
) (
    input  wire logic              clk,
    input  wire ara_pkg::ara_ctrl_t ctrl,
    input  wire logic [CW-1:0]     count,
    input  wire logic [CW-1:0]     pos,
    input  wire logic [48:0]       mark,
    input  wire logic [49:0]       prev_end,
    input  wire logic [47:0]       left_begin,
    input  wire logic [47:0]       left_len,
    input  wire logic [47:0]       right_begin,
    input  wire logic [47:0]       right_len,
    input  wire logic [47:0]       new_begin,
    input  wire logic [47:0]       new_len,
    input  wire logic [47:0]       req_addr,
    input  wire logic [47:0]       req_len,
    input  wire logic [48:0]       addr_end,
    input  wire logic [49:0]       align_mask,
    output logic [47:0]            begin_q,
    output logic [47:0]            len_q,
    output logic [49:0]            node_end,
    output logic [47:0]            start_q,
    output ara_pkg::ara_flags_t    flags
);
    import ara_pkg::*;

    logic [47:0] begin_reg, begin_next;
    logic [47:0] len_reg, len_next;
    logic [50:0] lo_reg;
    logic [49:0] hi_reg;
    logic        hi_ok_reg;
    logic        active_reg;
    logic [47:0] start_reg;
    ara_flags_t  flags_reg;
    logic        is_entry, is_active;
    logic [48:0] nb;
    logic [47:0] nlen;
    logic [50:0] start_w;
    logic [51:0] start_end;

    assign is_entry  = CW'(IDX) < count;
    assign is_active = CW'(IDX) <= count;
    assign nb        = is_entry ? {1'b0, begin_reg} : mark;
    assign nlen      = is_entry ? len_reg : 48'd0;
    assign node_end  = is_entry ? ({2'b0, begin_reg} + {2'b0, len_reg}) : {1'b0, mark};
    assign start_w   = (lo_reg + {1'b0, align_mask}) & ~{1'b0, align_mask};
    assign start_end = {1'b0, start_w} + {4'b0, req_len};

    always_comb
    begin
        begin_next = begin_reg;
        len_next   = len_reg;
        if (ctrl.ins)
        begin
            if (CW'(IDX) == pos)
            begin
                begin_next = new_begin;
                len_next   = new_len;
            end
            else if (CW'(IDX) > pos)
            begin
                begin_next = left_begin;
                len_next   = left_len;
            end
        end
        else if (ctrl.del && CW'(IDX) >= pos)
        begin
            begin_next = right_begin;
            len_next   = right_len;
        end
    end

    always_ff @(posedge clk)
    begin
        begin_reg <= begin_next;
        len_reg   <= len_next;
        if (ctrl.eval1)
        begin
            lo_reg            <= {1'b0, prev_end} + 51'(PAGE_BYTES);
            hi_reg            <= {1'b0, nb} - 50'(PAGE_BYTES);
            hi_ok_reg         <= nb >= 49'(PAGE_BYTES);
            active_reg        <= is_active;
            flags_reg.ge      <= is_active && (nb >= {1'b0, req_addr});
            flags_reg.eq      <= nb == {1'b0, req_addr};
            flags_reg.len_ok  <= req_len <= nlen;
            flags_reg.in_prev <= {1'b0, addr_end} <= prev_end;
        end
        if (ctrl.eval2)
        begin
            flags_reg.fit <= active_reg && hi_ok_reg && (start_end <= {2'b0, hi_reg});
            start_reg     <= start_w[47:0];
        end
    end

    assign begin_q = begin_reg;
    assign len_q   = len_reg;
    assign start_q = start_reg;
    assign flags   = flags_reg;

endmodule
`default_nettype wire

>>> tb/tb_address_region_allocator.sv
// Self-checking testbench for the address region allocator: directed table, then random traffic.
`timescale 1ns / 1ps
module tb_address_region_allocator;
    import ara_pkg::*;

    localparam int TABLE_DEPTH = 64;
    localparam longint unsigned GUARD = 64'd4096;
    localparam longint unsigned TOP = 64'h1_0000_0000_0000;
    localparam longint unsigned LOWER_SPAN = 64'h3FE0_0000;
    localparam longint unsigned MAX48 = 64'hFFFF_FFFF_FFFF;
    localparam longint unsigned BASE_A = 64'h4000_0000;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [1:0] OP_RESERVED = 2'd3;
    localparam logic [7:0] REG_SPARE = 8'd5;

    typedef struct {
        logic [47:0] addr;
        logic [1:0]  st;
        logic        alloc;
    } result_t;

    typedef struct {
        logic [1:0]  op;
        logic [47:0] addr;
        logic [47:0] len;
        bit          typed;
        result_t     res;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  opcode;
    logic [47:0] req_address;
    logic [47:0] req_length;
    logic        out_valid;
    logic        out_stall;
    logic [47:0] granted_address;
    logic [1:0]  status;
    logic        is_allocated;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_index;
    logic [47:0] cfg_data;

    longint unsigned region_start [TABLE_DEPTH];
    longint unsigned region_size [TABLE_DEPTH];
    int unsigned     region_cnt;
    longint unsigned win_base;
    longint unsigned win_len;

    result_t pending_results[$];
    row_t    dir_rows[$];
    int      mismatches;
    int      cycles;
    bit      hold_req;
    bit      no_idle;

    address_region_allocator i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .opcode(opcode), .req_address(req_address), .req_length(req_length),
        .out_valid(out_valid), .out_stall(out_stall),
        .granted_address(granted_address), .status(status), .is_allocated(is_allocated),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic longint unsigned clip_top(longint unsigned v);
        return (v > TOP) ? TOP : v;
    endfunction

    function automatic longint unsigned bound_start(int unsigned i);
        if (i == 0)
            return win_base;
        if (i > region_cnt)
            return clip_top(win_base + win_len);
        return region_start[i - 1];
    endfunction

    function automatic longint unsigned bound_stop(int unsigned i);
        if (i == 0)
            return clip_top(win_base + LOWER_SPAN);
        if (i > region_cnt)
            return clip_top(win_base + win_len);
        return region_start[i - 1] + region_size[i - 1];
    endfunction

    function automatic result_t apply_request(logic [1:0] op, longint unsigned addr,
                                              longint unsigned len);
        result_t         r;
        longint unsigned align;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned cb;
        longint unsigned s;
        int              k;
        int              j;
        int unsigned     n;
        int unsigned     i;
        bit              done;
        r.addr = '0;
        r.st = ST_SUCCESS;
        r.alloc = 1'b0;
        done = 1'b0;
        if (op == OP_ALLOC)
        begin
            if (region_cnt >= TABLE_DEPTH)
                r.st = ST_FULL;
            else
            begin
                if (len < SZ_2M)
                    align = SZ_64K;
                else if (len < SZ_4M)
                    align = SZ_2M;
                else if (len < SZ_32M)
                    align = SZ_4M;
                else if (len < SZ_1G)
                    align = SZ_32M;
                else
                    align = SZ_1G;
                for (k = region_cnt + 1; k >= 1 && !done; k--)
                begin
                    lo = bound_stop(k - 1) + GUARD;
                    cb = bound_start(k);
                    if (cb >= GUARD)
                    begin
                        hi = cb - GUARD;
                        if (!(hi < lo || hi - lo < len))
                        begin
                            s = (lo + align - 1) & ~(align - 1);
                            if (s + len <= hi)
                            begin
                                for (j = region_cnt; j > k - 1; j--)
                                begin
                                    region_start[j] = region_start[j - 1];
                                    region_size[j] = region_size[j - 1];
                                end
                                region_start[k - 1] = s & MAX48;
                                region_size[k - 1] = len;
                                region_cnt++;
                                r.addr = s[47:0];
                                done = 1'b1;
                            end
                        end
                    end
                end
                if (!done)
                    r.st = ST_NO_SPACE;
            end
        end
        else if (op == OP_FREE)
        begin
            r.st = ST_NOTFOUND;
            for (i = 0; i < region_cnt && !done; i++)
            begin
                if (region_start[i] == addr)
                begin
                    for (j = i; j + 1 < region_cnt; j++)
                    begin
                        region_start[j] = region_start[j + 1];
                        region_size[j] = region_size[j + 1];
                    end
                    region_cnt--;
                    r.st = ST_SUCCESS;
                    done = 1'b1;
                end
            end
        end
        else if (op == OP_CHECK)
        begin
            n = region_cnt + 2;
            for (i = 0; i < n; i++)
                if (bound_start(i) >= addr)
                    break;
            if (i == n)
                r.alloc = 1'b0;
            else if (bound_start(i) == addr)
                r.alloc = (len <= bound_stop(i) - bound_start(i));
            else if (i == 0)
                r.alloc = 1'b0;
            else
                r.alloc = (bound_start(i - 1) <= addr) && (addr + len <= bound_stop(i - 1));
        end
        else
            r.st = ST_NOTFOUND;
        return r;
    endfunction

    task automatic send_request(logic [1:0] op, logic [47:0] addr, logic [47:0] len,
                                bit typed, result_t typed_res);
        result_t r;
        in_valid <= 1'b1;
        opcode <= op;
        req_address <= addr;
        req_length <= len;
        do
            @(posedge clk);
        while (in_stall);
        r = apply_request(op, 64'(addr), 64'(len));
        pending_results.push_back(typed ? typed_res : r);
        if (!no_idle && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    task automatic write_register(logic [7:0] idx, logic [47:0] value);
        in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (10) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_WINDOW_BASE)
        begin
            win_base = 64'(value);
            region_cnt = 0;
        end
        else if (idx == REG_WINDOW_LENGTH)
        begin
            win_len = 64'(value);
            region_cnt = 0;
        end
    endtask

    function automatic logic [47:0] pick_length();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 48'($urandom_range(0, 32'h1F_FFFF));
            4: return 48'($urandom_range(32'h20_0000, 32'h3F_FFFF));
            5: return 48'($urandom_range(32'h40_0000, 32'h1FF_FFFF));
            6: return 48'($urandom_range(32'h200_0000, 32'h3FFF_FFFF));
            7: return 48'($urandom_range(32'h4000_0000, 32'hFFFF_FFFF));
            default: return 48'({$urandom, $urandom});
        endcase
    endfunction

    function automatic logic [47:0] pick_address(bit exact);
        int unsigned j;
        if (region_cnt > 0 && $urandom_range(0, 3) != 0)
        begin
            j = $urandom_range(0, region_cnt - 1);
            if (exact)
                return region_start[j][47:0];
            return 48'(region_start[j] + $urandom_range(0, 32'h1_FFFF));
        end
        if ($urandom_range(0, 1) == 0)
            return 48'(win_base + $urandom_range(0, 32'h3FFF_FFFF));
        return 48'({$urandom, $urandom});
    endfunction

    task automatic random_phase(int count, int alloc_weight, int hold_at, int pause_at);
        int          i;
        int          w;
        logic [1:0]  op;
        result_t     none;
        none = '{default: '0};
        for (i = 0; i < count; i++)
        begin
            if (i == hold_at)
                hold_req = 1'b1;
            if (i == pause_at)
            begin
                in_valid <= 1'b0;
                wait (pending_results.size() == 0);
                @(posedge clk);
            end
            w = $urandom_range(0, 99);
            if (w < alloc_weight)
                op = OP_ALLOC;
            else if (w < alloc_weight + (100 - alloc_weight) / 2)
                op = OP_FREE;
            else if (w < 96)
                op = OP_CHECK;
            else
                op = OP_RESERVED;
            send_request(op, pick_address(op == OP_FREE), pick_length(), 1'b0, none);
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transaction: addr=%h status=%0d alloc=%0b",
                             granted_address, status, is_allocated);
            end
            else
            begin
                want = pending_results.pop_front();
                if (want.addr !== granted_address || want.st !== status ||
                    want.alloc !== is_allocated)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected addr=%h status=%0d alloc=%0b, ",
                                  "got addr=%h status=%0d alloc=%0b"},
                                 want.addr, want.st, want.alloc,
                                 granted_address, status, is_allocated);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        bit v;
        int n;
        out_stall <= 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                v = 1'b1;
                n = 300;
            end
            else if (no_idle)
            begin
                v = 1'b0;
                n = 1;
            end
            else
            begin
                v = ($urandom_range(0, 2) == 0);
                n = $urandom_range(1, 12);
            end
            out_stall <= v;
            repeat (n) @(posedge clk);
            if (v && n == 300)
                hold_req = 1'b0;
        end
    end

    initial
    begin
        result_t none;
        int      i;
        none = '{default: '0};
        mismatches = 0;
        cycles = 0;
        hold_req = 1'b0;
        no_idle = 1'b0;
        region_cnt = 0;
        win_base = 0;
        win_len = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        opcode = OP_ALLOC;
        req_address = '0;
        req_length = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;

        // Rows 0 to 4 run on the reset window; the rest on window BASE_A, 4 GB.
        dir_rows.push_back('{OP_ALLOC, 48'h0, 48'h0, 1'b1, '{48'h0, ST_NO_SPACE, 1'b0}});
        dir_rows.push_back('{OP_FREE, 48'h0, 48'h0, 1'b1, '{48'h0, ST_NOTFOUND, 1'b0}});
        dir_rows.push_back('{OP_CHECK, 48'h0, 48'h0, 1'b1, '{48'h0, ST_SUCCESS, 1'b1}});
        dir_rows.push_back('{OP_CHECK, MAX48[47:0], MAX48[47:0], 1'b1,
                             '{48'h0, ST_SUCCESS, 1'b0}});
        dir_rows.push_back('{OP_RESERVED, MAX48[47:0], MAX48[47:0], 1'b1,
                             '{48'h0, ST_NOTFOUND, 1'b0}});
        dir_rows.push_back('{OP_ALLOC, 48'h0, 48'h1000, 1'b1,
                             '{48'h7FE1_0000, ST_SUCCESS, 1'b0}});
        dir_rows.push_back('{OP_ALLOC, 48'h0, 48'h0, 1'b0, none});
        dir_rows.push_back('{OP_ALLOC, 48'h0, 48'h1F_FFFF, 1'b0, none});
        dir_rows.push_back('{OP_ALLOC, 48'h0, 48'h20_0000, 1'b0, none});
        dir_rows.push_back('{OP_ALLOC, 48'h0, 48'h3F_FFFF, 1'b0, none});
        dir_rows.push_back('{OP_ALLOC, 48'h0, 48'h200_0000, 1'b0, none});
        dir_rows.push_back('{OP_ALLOC, 48'h0, 48'h4000_0000, 1'b0, none});
        dir_rows.push_back('{OP_ALLOC, 48'h0, MAX48[47:0], 1'b1,
                             '{48'h0, ST_NO_SPACE, 1'b0}});
        dir_rows.push_back('{OP_FREE, BASE_A[47:0], 48'h0, 1'b1,
                             '{48'h0, ST_NOTFOUND, 1'b0}});
        dir_rows.push_back('{OP_FREE, 48'h7FE1_0000, 48'h0, 1'b1,
                             '{48'h0, ST_SUCCESS, 1'b0}});
        dir_rows.push_back('{OP_FREE, 48'h7FE1_0000, 48'h0, 1'b1,
                             '{48'h0, ST_NOTFOUND, 1'b0}});
        dir_rows.push_back('{OP_CHECK, 48'h4000_1000, 48'h1000, 1'b1,
                             '{48'h0, ST_SUCCESS, 1'b1}});
        dir_rows.push_back('{OP_CHECK, 48'h4000_0000, 48'h3FE0_0001, 1'b1,
                             '{48'h0, ST_SUCCESS, 1'b0}});
        dir_rows.push_back('{OP_CHECK, 48'h1_4000_0000, 48'h0, 1'b0, none});
        dir_rows.push_back('{OP_CHECK, 48'h7FE0_0000, 48'h10, 1'b0, none});
        dir_rows.push_back('{OP_RESERVED, 48'h0, 48'h0, 1'b1,
                             '{48'h0, ST_NOTFOUND, 1'b0}});

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < dir_rows.size(); i++)
        begin
            if (i == 5)
            begin
                write_register(REG_WINDOW_BASE, BASE_A[47:0]);
                write_register(REG_WINDOW_LENGTH, 48'h1_0000_0000);
            end
            send_request(dir_rows[i].op, dir_rows[i].addr, dir_rows[i].len,
                         dir_rows[i].typed, dir_rows[i].res);
        end

        random_phase(110, 85, 40, -1);
        write_register(REG_SPARE, 48'h1234_5678);
        random_phase(60, 50, -1, 30);
        write_register(REG_WINDOW_BASE, 48'hFFFF_C000_0000);
        write_register(REG_WINDOW_LENGTH, MAX48[47:0]);
        random_phase(60, 60, -1, -1);
        write_register(REG_WINDOW_BASE, 48'h0);
        random_phase(70, 60, -1, -1);
        write_register(REG_WINDOW_BASE, MAX48[47:0]);
        random_phase(40, 60, -1, -1);
        write_register(REG_WINDOW_BASE, BASE_A[47:0]);
        write_register(REG_WINDOW_LENGTH, 48'h10_0000);
        random_phase(40, 60, -1, -1);
        write_register(REG_WINDOW_LENGTH, 48'h2_0000_0000);
        random_phase(40, 70, -1, -1);
        no_idle = 1'b1;
        random_phase(80, 60, -1, -1);

        in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
